// ===== rtl/assert_macros.svh =====
// assertion helpers for the filter bank
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// a implies b in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
// a implies b in the next cycle
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif

`endif

// ===== rtl/fbf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package fbf_pkg;

  localparam int SMP_W = 16;
  localparam int GAIN_W = 20;
  localparam int TAPS_W = 9;
  localparam int NUM_CFG_BANDS = 4;
  localparam int FRAC_SHIFT = 29;

  typedef logic signed [GAIN_W-1:0] gain_t;
  typedef logic [TAPS_W-1:0] taps_t;
  typedef logic [2:0] reg_idx_t;

  // register indexes
  localparam reg_idx_t REG_GAIN_BAND0 = 3'd0;
  localparam reg_idx_t REG_GAIN_BAND3 = 3'd3;
  localparam reg_idx_t REG_TAPS_BAND0 = 3'd4;
  localparam reg_idx_t REG_TAPS_BAND3 = 3'd7;

  localparam gain_t GAIN_RESET [NUM_CFG_BANDS] = '{
    20'sd16384, 20'sd16384, 20'sd163840, 20'sd16384};
  localparam taps_t TAPS_RESET [NUM_CFG_BANDS] = '{9'd163, 9'd131, 9'd67, 9'd23};

  // clamp bounds with 44 fraction bits
  localparam longint CLAMP_HIGH = 64'sd17591482356974;
  localparam longint CLAMP_LOW = -(64'sd1 <<< 44);
  localparam logic [SMP_W-1:0] Q15_HIGH = 16'h7FFE;
  localparam logic [SMP_W-1:0] Q15_LOW = 16'h8000;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_WRITE, S_MAC, S_DRAIN,
    S_GAIN_LO, S_GAIN_HI, S_GAIN_ADD, S_OUT
  } state_t;

  typedef struct packed {
    logic clear_wr;
    logic accept;
    logic write_sample;
    logic band_start;
    logic issue;
    logic gain_lo;
    logic gain_hi;
    logic gain_add;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic mac_busy;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// ===== rtl/fbf_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
module fbf_cfg import fbf_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_write_en,
  input  wire reg_idx_t        cfg_index,
  input  wire logic [GAIN_W-1:0] cfg_data,
  output gain_t                gain [NUM_CFG_BANDS],
  output taps_t                taps [NUM_CFG_BANDS]
);

  // gain and tap count registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_CFG_BANDS; k++) begin
        gain[k] <= GAIN_RESET[k];
        taps[k] <= TAPS_RESET[k];
      end
    end else if (cfg_write_en) begin
      case (cfg_index) inside
        [REG_GAIN_BAND0:REG_GAIN_BAND3]: gain[cfg_index[1:0]] <= cfg_data;
        [REG_TAPS_BAND0:REG_TAPS_BAND3]: taps[cfg_index[1:0]] <= cfg_data[TAPS_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/fbf_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module fbf_ctrl import fbf_pkg::*; #(
  parameter int NUM_BANDS_P = 4,
  parameter int MAX_TAPS = 256,
  localparam int TW = $clog2(MAX_TAPS),
  localparam int CW = $clog2(MAX_TAPS + 1),
  localparam int BNW = (NUM_BANDS_P > 1) ? $clog2(NUM_BANDS_P) : 1,
  localparam int DEPTH = NUM_BANDS_P * MAX_TAPS,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  input  wire logic     operation,
  input  wire taps_t    taps [NUM_CFG_BANDS],
  input  wire status_t  status,
  output logic          in_ready,
  output cmd_t          cmd,
  output logic [BNW-1:0] band,
  output logic [TW-1:0] tap,
  output logic [AW-1:0] clr_addr
);

  state_t state, state_next;
  logic [CW-1:0] tap_cnt;
  logic [CW-1:0] ntaps;

  // tap count of the current band, saturated
  always_comb begin
    ntaps = '0;
    for (int k = 0; k < NUM_CFG_BANDS; k++) begin
      if (int'(band) == k) begin
        if (int'(taps[k]) > MAX_TAPS) ntaps = CW'(MAX_TAPS);
        else ntaps = CW'(taps[k]);
      end
    end
  end

  assign tap = tap_cnt[TW-1:0];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_addr == AW'(DEPTH - 1)) state_next = S_IDLE;
      S_IDLE: if (in_valid && !operation) state_next = S_WRITE;
      S_WRITE: state_next = (ntaps == '0) ? S_GAIN_LO : S_MAC;
      S_MAC: if (tap_cnt == ntaps - CW'(1)) state_next = S_DRAIN;
      S_DRAIN: if (!status.mac_busy) state_next = S_GAIN_LO;
      S_GAIN_LO: state_next = S_GAIN_HI;
      S_GAIN_HI: state_next = S_GAIN_ADD;
      S_GAIN_ADD: state_next = (int'(band) == NUM_BANDS_P - 1) ? S_OUT : S_WRITE;
      S_OUT: if (status.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      S_CLEAR: cmd.clear_wr = 1'b1;
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.accept = in_valid;
      end
      S_WRITE: begin
        cmd.write_sample = 1'b1;
        cmd.band_start = 1'b1;
      end
      S_MAC: cmd.issue = 1'b1;
      S_GAIN_LO: cmd.gain_lo = 1'b1;
      S_GAIN_HI: cmd.gain_hi = 1'b1;
      S_GAIN_ADD: cmd.gain_add = 1'b1;
      S_OUT: cmd.out_load = status.out_free;
      default: ;
    endcase
  end

  // state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      band <= '0;
      tap_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_addr <= clr_addr + AW'(1);
      if (state == S_IDLE) band <= '0;
      else if (state == S_GAIN_ADD) band <= band + BNW'(1);
      if (state == S_WRITE) tap_cnt <= '0;
      else if (state == S_MAC) tap_cnt <= tap_cnt + CW'(1);
    end
  end

  `ASSERT_IMPLIES(a_issue_in_range, clk, rst, cmd.issue, tap_cnt < ntaps)
  `ASSERT_IMPLIES(a_gain_after_drain, clk, rst, cmd.gain_lo, !status.mac_busy)
  `ASSERT_NEXT(a_out_then_idle, clk, rst, cmd.out_load, state == S_IDLE)
  `ASSERT_IMPLIES(a_ready_quiet, clk, rst, in_ready, !status.mac_busy)

endmodule
`default_nettype wire

// ===== rtl/fbf_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module fbf_dp import fbf_pkg::*; #(
  parameter int NUM_BANDS_P = 4,
  parameter int MAX_TAPS = 256,
  localparam int TW = $clog2(MAX_TAPS),
  localparam int BNW = (NUM_BANDS_P > 1) ? $clog2(NUM_BANDS_P) : 1,
  localparam int DEPTH = NUM_BANDS_P * MAX_TAPS,
  localparam int AW = $clog2(DEPTH),
  localparam int ACC_W = 2 * SMP_W + TW,
  localparam int HALF = ACC_W / 2,
  localparam int PP_W = HALF + 1 + GAIN_W,
  localparam int SUM_W = ACC_W + GAIN_W + BNW + 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cmd_t              cmd,
  output status_t                status,
  input  wire logic [BNW-1:0]    band,
  input  wire logic [TW-1:0]     tap,
  input  wire logic [AW-1:0]     clr_addr,
  input  wire logic              operation,
  input  wire logic signed [SMP_W-1:0] left_in,
  input  wire logic signed [SMP_W-1:0] right_in,
  input  wire logic [1:0]        band_index,
  input  wire logic [7:0]        tap_index,
  input  wire logic signed [SMP_W-1:0] coefficient,
  input  wire gain_t             gain [NUM_CFG_BANDS],
  input  wire logic              out_ready,
  output logic                   out_valid,
  output logic signed [SMP_W-1:0] left_out,
  output logic signed [SMP_W-1:0] right_out
);

  localparam logic signed [SUM_W-1:0] CLH = SUM_W'(CLAMP_HIGH);
  localparam logic signed [SUM_W-1:0] CLL = SUM_W'(CLAMP_LOW);

  logic [SMP_W-1:0] left_mem [DEPTH];
  logic [SMP_W-1:0] right_mem [DEPTH];
  logic [SMP_W-1:0] coef_mem [DEPTH];

  logic [TW-1:0] wp [NUM_BANDS_P];
  logic [TW-1:0] wp_cur;
  logic [TW-1:0] rd_idx;
  logic [AW-1:0] base, rd_addr, coef_rd_addr, wr_addr, coef_wr_addr;
  logic sample_we, load_ok;
  logic signed [SMP_W-1:0] smp_l, smp_r, wr_l, wr_r;
  logic signed [SMP_W-1:0] dl, dr, dc;
  logic v1, v2;
  logic signed [2*SMP_W-1:0] prod_l, prod_r;
  logic signed [ACC_W-1:0] acc_l, acc_r;
  gain_t gsel;
  logic signed [HALF:0] mop_l, mop_r;
  logic signed [PP_W-1:0] pp_l, pp_r;
  logic signed [SUM_W-1:0] sum_l, sum_r;
  logic [SMP_W-1:0] q_l, q_r;

  // addressing: band base plus circular index
  assign wp_cur = wp[band];
  assign base = AW'(int'(band) * MAX_TAPS);
  always_comb begin
    if (wp_cur >= tap) rd_idx = wp_cur - tap;
    else rd_idx = TW'(({1'b0, wp_cur} + (TW + 1)'(MAX_TAPS)) - {1'b0, tap});
  end
  assign rd_addr = base + AW'(rd_idx);
  assign coef_rd_addr = base + AW'(tap);
  assign wr_addr = cmd.clear_wr ? clr_addr : base + AW'(wp_cur);
  assign sample_we = cmd.clear_wr | cmd.write_sample;
  assign wr_l = cmd.clear_wr ? '0 : smp_l;
  assign wr_r = cmd.clear_wr ? '0 : smp_r;
  assign load_ok = cmd.accept && operation && (int'(band_index) < NUM_BANDS_P)
                   && (int'(tap_index) < MAX_TAPS);
  assign coef_wr_addr = AW'(int'(band_index) * MAX_TAPS + int'(tap_index));

  // delay lines
  always_ff @(posedge clk) begin
    if (sample_we) begin
      left_mem[wr_addr] <= wr_l;
      right_mem[wr_addr] <= wr_r;
    end
    if (cmd.issue) begin
      dl <= left_mem[rd_addr];
      dr <= right_mem[rd_addr];
    end
  end

  // coefficient store
  always_ff @(posedge clk) begin
    if (load_ok) coef_mem[coef_wr_addr] <= coefficient;
    if (cmd.issue) dc <= coef_mem[coef_rd_addr];
  end

  // input sample latch
  always_ff @(posedge clk) begin
    if (cmd.accept && !operation) begin
      smp_l <= left_in;
      smp_r <= right_in;
    end
  end

  // write positions
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_BANDS_P; k++) wp[k] <= '0;
    end else if (cmd.gain_add) begin
      wp[band] <= (wp_cur == TW'(MAX_TAPS - 1)) ? '0 : wp_cur + TW'(1);
    end
  end

  // mac pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
    end
  end

  // multiply and accumulate
  always_ff @(posedge clk) begin
    prod_l <= dl * dc;
    prod_r <= dr * dc;
    if (cmd.band_start) begin
      acc_l <= '0;
      acc_r <= '0;
    end else if (v2) begin
      acc_l <= acc_l + ACC_W'(prod_l);
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  assign status.mac_busy = v1 | v2;

  // band gain
  always_comb begin
    gsel = '0;
    for (int k = 0; k < NUM_CFG_BANDS; k++) begin
      if (int'(band) == k) gsel = gain[k];
    end
  end

  // gain product split in two halves of the accumulator
  assign mop_l = cmd.gain_hi ? (HALF + 1)'($signed(acc_l[ACC_W-1:HALF]))
                             : $signed({1'b0, acc_l[HALF-1:0]});
  assign mop_r = cmd.gain_hi ? (HALF + 1)'($signed(acc_r[ACC_W-1:HALF]))
                             : $signed({1'b0, acc_r[HALF-1:0]});

  always_ff @(posedge clk) begin
    if (cmd.gain_lo || cmd.gain_hi) begin
      pp_l <= mop_l * gsel;
      pp_r <= mop_r * gsel;
    end
  end

  // band sum
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sum_l <= '0;
      sum_r <= '0;
    end else if (cmd.gain_hi) begin
      sum_l <= sum_l + SUM_W'(pp_l);
      sum_r <= sum_r + SUM_W'(pp_r);
    end else if (cmd.gain_add) begin
      sum_l <= sum_l + (SUM_W'(pp_l) <<< HALF);
      sum_r <= sum_r + (SUM_W'(pp_r) <<< HALF);
    end
  end

  // clamp and truncate to q1.15
  always_comb begin
    if (sum_l > CLH) q_l = Q15_HIGH;
    else if (sum_l < CLL) q_l = Q15_LOW;
    else q_l = sum_l[FRAC_SHIFT+SMP_W-1:FRAC_SHIFT];
    if (sum_r > CLH) q_r = Q15_HIGH;
    else if (sum_r < CLL) q_r = Q15_LOW;
    else q_r = sum_r[FRAC_SHIFT+SMP_W-1:FRAC_SHIFT];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      left_out <= q_l;
      right_out <= q_r;
    end
  end

  assign status.out_free = !out_valid || out_ready;

endmodule
`default_nettype wire

// ===== rtl/four_band_fir_filter_bank_unit.sv =====
// sequence: per band a WRITE state, a MAC state (one MAC per tap per channel), DRAIN, then
//   GAIN_LO, GAIN_HI, GAIN_ADD (zero taps skip MAC and DRAIN); S_OUT then loads the result
// words: one word at a time; after a sample word no word is taken until its result is loaded,
//   load words stay in S_IDLE; the shared MAC loop over all band taps sets the rate
// reset: clearing pass over all delay line entries (bands x max taps) before ready
// reset: gains and tap counts return to defaults, coefficients are undefined until loaded
`timescale 1ns / 1ps
`default_nettype none
module four_band_fir_filter_bank_unit import fbf_pkg::*; #(
  parameter int NUM_BANDS_P = 4,
  parameter int MAX_TAPS = 256
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              operation,
  input  wire logic signed [15:0] left_in,
  input  wire logic signed [15:0] right_in,
  input  wire logic [1:0]        band_index,
  input  wire logic [7:0]        tap_index,
  input  wire logic signed [15:0] coefficient,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic signed [15:0]     left_out,
  output logic signed [15:0]     right_out,
  input  wire logic              cfg_write_en,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [19:0]       cfg_data
);

  localparam int TW = $clog2(MAX_TAPS);
  localparam int BNW = (NUM_BANDS_P > 1) ? $clog2(NUM_BANDS_P) : 1;
  localparam int AW = $clog2(NUM_BANDS_P * MAX_TAPS);

  gain_t gain [NUM_CFG_BANDS];
  taps_t taps [NUM_CFG_BANDS];
  cmd_t cmd;
  status_t status;
  logic [BNW-1:0] band;
  logic [TW-1:0] tap;
  logic [AW-1:0] clr_addr;

  fbf_cfg u_cfg (
    .clk, .rst, .cfg_write_en, .cfg_index, .cfg_data, .gain, .taps
  );

  fbf_ctrl #(.NUM_BANDS_P(NUM_BANDS_P), .MAX_TAPS(MAX_TAPS)) u_ctrl (
    .clk, .rst, .in_valid, .operation, .taps, .status,
    .in_ready, .cmd, .band, .tap, .clr_addr
  );

  fbf_dp #(.NUM_BANDS_P(NUM_BANDS_P), .MAX_TAPS(MAX_TAPS)) u_dp (
    .clk, .rst, .cmd, .status, .band, .tap, .clr_addr,
    .operation, .left_in, .right_in, .band_index, .tap_index, .coefficient,
    .gain, .out_ready, .out_valid, .left_out, .right_out
  );

endmodule
`default_nettype wire

// ===== tb/four_band_fir_filter_bank_unit_tb.sv =====
`timescale 1ns / 1ps
module four_band_fir_filter_bank_unit_tb;
  import fbf_pkg::*;

  localparam logic OP_FILTER = 1'b0;
  localparam logic OP_LOAD = 1'b1;
  localparam int BANDS = 4;
  localparam int DEPTH = 256;
  localparam int SETTLE_CYCLES = 1200;

  typedef struct {
    logic              op;
    logic signed [15:0] l;
    logic signed [15:0] r;
    logic [1:0]        band;
    logic [7:0]        tap;
    logic signed [15:0] coef;
  } word_t;

  typedef struct {
    logic signed [15:0] l;
    logic signed [15:0] r;
  } pair_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic operation = 1'b0;
  logic signed [15:0] left_in = '0;
  logic signed [15:0] right_in = '0;
  logic [1:0] band_index = '0;
  logic [7:0] tap_index = '0;
  logic signed [15:0] coefficient = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] left_out;
  logic signed [15:0] right_out;
  logic cfg_write_en = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [19:0] cfg_data = '0;

  // predictor state
  gain_t gain_copy [BANDS];
  taps_t taps_copy [BANDS];
  logic signed [15:0] left_line [BANDS][DEPTH];
  logic signed [15:0] right_line [BANDS][DEPTH];
  logic signed [15:0] coef_store [BANDS][DEPTH];
  int unsigned line_pos [BANDS];

  word_t pending_words[$];
  pair_t expected_pairs[$];
  word_t cur_word;
  int idle_left = 0;
  int stall_left = 0;
  bit calm = 1'b0;
  int mismatches = 0;
  int failures = 0;
  int samples_checked = 0;
  int loads_sent = 0;

  four_band_fir_filter_bank_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .left_in(left_in), .right_in(right_in),
    .band_index(band_index), .tap_index(tap_index), .coefficient(coefficient),
    .out_valid(out_valid), .out_ready(out_ready),
    .left_out(left_out), .right_out(right_out),
    .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // clamp the 44 fraction bit sum and floor it to q1.15
  function automatic logic signed [15:0] clamp_to_q15(longint s);
    longint v;
    v = s;
    if (v > CLAMP_HIGH) v = CLAMP_HIGH;
    if (v < CLAMP_LOW) v = CLAMP_LOW;
    v = (v - CLAMP_LOW) >>> FRAC_SHIFT;
    return 16'(v - 32768);
  endfunction

  // apply one accepted word to the filter bank copy
  function automatic void absorb_word(word_t w);
    longint sum_l, sum_r, acc_l, acc_r, c;
    int unsigned wp, n, idx;
    pair_t res;
    if (w.op == OP_LOAD) begin
      coef_store[w.band][w.tap] = w.coef;
      return;
    end
    sum_l = 0;
    sum_r = 0;
    for (int b = 0; b < BANDS; b++) begin
      wp = line_pos[b];
      left_line[b][wp] = w.l;
      right_line[b][wp] = w.r;
      n = (taps_copy[b] > DEPTH) ? DEPTH : taps_copy[b];
      acc_l = 0;
      acc_r = 0;
      for (int unsigned i = 0; i < n; i++) begin
        idx = (wp + DEPTH - i) % DEPTH;
        c = longint'(coef_store[b][i]);
        acc_l += longint'(left_line[b][idx]) * c;
        acc_r += longint'(right_line[b][idx]) * c;
      end
      sum_l += acc_l * longint'(gain_copy[b]);
      sum_r += acc_r * longint'(gain_copy[b]);
      line_pos[b] = (wp + 1) % DEPTH;
    end
    res.l = clamp_to_q15(sum_l);
    res.r = clamp_to_q15(sum_r);
    expected_pairs.push_back(res);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // sender side
  always @(posedge clk) begin : driver
    logic fire;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      fire = in_valid && in_ready;
      if (fire) absorb_word(cur_word);
      if (!in_valid || fire) begin
        if (idle_left > 0) begin
          idle_left = idle_left - 1;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          cur_word = pending_words.pop_front();
          operation <= cur_word.op;
          left_in <= cur_word.l;
          right_in <= cur_word.r;
          band_index <= cur_word.band;
          tap_index <= cur_word.tap;
          coefficient <= cur_word.coef;
          in_valid <= 1'b1;
          idle_left = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver side and result check
  always @(posedge clk) begin : monitor
    pair_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        samples_checked++;
        if (expected_pairs.size() == 0) begin
          failures++;
          if (mismatches < 10)
            $display("unexpected result word: left %0d right %0d", left_out, right_out);
          mismatches++;
        end else begin
          want = expected_pairs.pop_front();
          if (left_out !== want.l || right_out !== want.r) begin
            failures++;
            if (mismatches < 10)
              $display("mismatch: left exp %0d got %0d, right exp %0d got %0d",
                       want.l, left_out, want.r, right_out);
            mismatches++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [19:0] data);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx <= REG_GAIN_BAND3) gain_copy[idx] = gain_t'(data);
    else taps_copy[idx - REG_TAPS_BAND0] = taps_t'(data[8:0]);
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  task automatic set_bands(gain_t g [BANDS], taps_t t [BANDS]);
    for (int b = 0; b < BANDS; b++) begin
      write_reg(reg_idx_t'(REG_GAIN_BAND0 + b), 20'(g[b]));
      write_reg(reg_idx_t'(REG_TAPS_BAND0 + b), 20'(t[b]));
    end
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || in_valid || expected_pairs.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_sample(logic signed [15:0] l, logic signed [15:0] r);
    word_t w;
    w.op = OP_FILTER;
    w.l = l;
    w.r = r;
    w.band = 2'($urandom);
    w.tap = 8'($urandom);
    w.coef = 16'($urandom);
    pending_words.push_back(w);
  endtask

  task automatic push_load(logic [1:0] band, logic [7:0] tap, logic signed [15:0] c);
    word_t w;
    w.op = OP_LOAD;
    w.l = 16'($urandom);
    w.r = 16'($urandom);
    w.band = band;
    w.tap = tap;
    w.coef = c;
    pending_words.push_back(w);
    loads_sent++;
  endtask

  function automatic logic signed [15:0] rand_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'sh7FFF;
    if (r == 1) return 16'sh8000;
    if (r < 5) return 16'($signed($urandom_range(0, 2047)) - 1024);
    return 16'($urandom);
  endfunction

  function automatic gain_t rand_gain();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return gain_t'($signed($urandom_range(0, 32768)) - 16384);
    if (r < 6) return gain_t'($signed($urandom_range(0, 4096)) - 2048);
    return gain_t'($urandom);
  endfunction

  // stimulus
  initial begin : stimulus
    gain_t g [BANDS];
    taps_t t [BANDS];
    for (int b = 0; b < BANDS; b++) begin
      gain_copy[b] = GAIN_RESET[b];
      taps_copy[b] = TAPS_RESET[b];
      line_pos[b] = 0;
      for (int i = 0; i < DEPTH; i++) begin
        left_line[b][i] = '0;
        right_line[b][i] = '0;
        coef_store[b][i] = '0;
      end
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // fill every coefficient so no undefined entry is ever read
    for (int b = 0; b < BANDS; b++)
      for (int i = 0; i < DEPTH; i++)
        push_load(2'(b), 8'(i), (i == 0 && b == 0) ? 16'sh8000 :
                  (i == 1 && b == 0) ? 16'sh7FFF : 16'($signed($urandom_range(0, 4095)) - 2048));

    // directed words under reset settings
    push_sample(16'sh7FFF, 16'sh8000);
    push_sample(16'sh8000, 16'sh7FFF);
    push_sample(16'sh0000, 16'sh0000);
    push_sample(16'sh7FFF, 16'sh7FFF);
    push_sample(16'sh8000, 16'sh8000);
    push_sample(16'sh0001, 16'shFFFF);
    push_load(2'd3, 8'd255, 16'sh7FFF);
    push_load(2'd2, 8'd0, 16'sh8000);
    push_sample(16'sh1234, 16'shEDCB);
    push_sample(16'sh0000, 16'sh7FFF);
    drain();

    // extreme gains, full and zero tap counts, saturated tap count
    g = '{gain_t'(20'h7FFFF), gain_t'(20'h80000), gain_t'(20'h00000), gain_t'(20'h00001)};
    t = '{taps_t'(256), taps_t'(0), taps_t'(511), taps_t'(1)};
    set_bands(g, t);
    push_sample(16'sh7FFF, 16'sh8000);
    push_sample(16'sh0100, 16'shFF00);
    push_sample(16'sh8000, 16'sh0001);
    push_sample(16'sh0000, 16'sh0000);
    drain();
    g = '{gain_t'(20'h80000), gain_t'(20'h7FFFF), gain_t'(20'h7FFFF), gain_t'(20'h80000)};
    t = '{taps_t'(1), taps_t'(256), taps_t'(2), taps_t'(0)};
    set_bands(g, t);
    push_sample(16'sh0001, 16'shFFFF);
    push_sample(16'sh7FFF, 16'sh8000);
    drain();

    // random phases with small tap counts; the drain between phases
    // makes the sender wait for every expected result
    for (int ph = 0; ph < 2; ph++) begin
      calm = (ph == 1);
      for (int b = 0; b < BANDS; b++) begin
        g[b] = rand_gain();
        t[b] = ($urandom_range(0, 9) == 0) ? taps_t'($urandom_range(0, 40))
                                           : taps_t'($urandom_range(1, 12));
      end
      set_bands(g, t);
      for (int n = 0; n < 250; n++) begin
        if ($urandom_range(0, 99) < 15)
          push_load(2'($urandom), 8'($urandom), 16'($urandom));
        else
          push_sample(rand_sample(), rand_sample());
      end
      drain();
    end
    calm = 1'b0;

    // a few words with every band at full length
    for (int b = 0; b < BANDS; b++) begin
      g[b] = rand_gain();
      t[b] = taps_t'(256);
    end
    set_bands(g, t);
    for (int n = 0; n < 6; n++) push_sample(rand_sample(), rand_sample());
    drain();

    $display("covered %0d checked sample words and %0d coefficient loads", samples_checked,
             loads_sent);
    $display("settings: reset values, extreme gains, tap counts 0 to 511, random phases");
    if (failures == 0 && expected_pairs.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #50ms;
    $display("FAIL");
    $finish;
  end

endmodule
